[rtl/assert_macros.svh]
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[rtl/tpc_pkg.sv]
// shared constants and types for the touch pad press classifier
`timescale 1ns / 1ps
package tpc_pkg;
    localparam int RAW_BITS  = 22;
    localparam int TIME_BITS = 48;
    localparam int DUR_BITS  = 32;
    localparam int CFG_BITS  = (RAW_BITS > DUR_BITS) ? RAW_BITS : DUR_BITS;
    localparam int ADDR_BITS = 2;

    localparam logic [ADDR_BITS-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [ADDR_BITS-1:0] REG_LONG_US   = 2'd1;
    localparam logic [ADDR_BITS-1:0] REG_LOCK_US   = 2'd2;

    localparam logic [DUR_BITS-1:0] LONG_US_RESET = 32'd1000000;
    localparam logic [DUR_BITS-1:0] LOCK_US_RESET = 32'd2500000;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_SHORT = 2'd1,
        EV_LONG  = 2'd2
    } ev_t;

    typedef struct packed {
        logic touching;
        logic above;
        ev_t  event_code;
        logic held_long;
        logic held_lock;
    } pad_stat_t;
endpackage

[rtl/tpc_pad.sv]
// one pad: touch detect, press start time and release classification
`timescale 1ns / 1ps
module tpc_pad (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [tpc_pkg::RAW_BITS-1:0]  raw,
    input  logic [tpc_pkg::TIME_BITS-1:0] now,
    input  logic [tpc_pkg::RAW_BITS-1:0]  threshold,
    input  logic [tpc_pkg::DUR_BITS-1:0]  long_us,
    input  logic [tpc_pkg::DUR_BITS-1:0]  lock_us,
    output tpc_pkg::pad_stat_t            stat
);
    logic                          touching_reg;
    logic                          touching_next;
    logic [tpc_pkg::TIME_BITS-1:0] start_reg;
    logic [tpc_pkg::TIME_BITS-1:0] start_next;
    logic [tpc_pkg::TIME_BITS-1:0] elapsed;
    logic                          above;
    logic                          new_press;
    logic                          ge_long;
    logic                          ge_lock;

    always_comb
    begin
        above      = raw > threshold;
        new_press  = above && !touching_reg;
        // wraps modulo the timestamp width
        elapsed    = now - start_reg;
        ge_long    = elapsed >= tpc_pkg::TIME_BITS'(long_us);
        ge_lock    = elapsed >= tpc_pkg::TIME_BITS'(lock_us);
        touching_next = above;
        start_next = new_press ? now : start_reg;

        stat.touching   = above;
        stat.above      = above;
        stat.event_code = tpc_pkg::EV_NONE;
        if (!above && touching_reg)
        begin
            stat.event_code = ge_long ? tpc_pkg::EV_LONG : tpc_pkg::EV_SHORT;
        end
        // a fresh press has zero duration
        stat.held_long = new_press ? (long_us == '0) : ge_long;
        stat.held_lock = new_press ? (lock_us == '0) : ge_lock;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touching_reg <= 1'b0;
        end
        else if (advance)
        begin
            touching_reg <= touching_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            start_reg <= start_next;
        end
    end
endmodule

[rtl/touch_pad_press_classifier.sv]
// top level of the touch pad press classifier
// an accepted input beat passes through the input register, then the result register
// throughput: one scan per cycle while out_ready stays high, set by the input register feeding the result register
// the result register holds a finished beat while the next scan waits in the input register
// reset: asynchronous active low; clears pad touch flags, lock state and valid flags
// reset config: threshold 0, long press 1000000 us, lock hold 2500000 us
`timescale 1ns / 1ps
`include "assert_macros.svh"
module touch_pad_press_classifier (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_wr_en,
    input  logic [tpc_pkg::ADDR_BITS-1:0] cfg_addr,
    input  logic [tpc_pkg::CFG_BITS-1:0]  cfg_data,
    // scan input
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tpc_pkg::RAW_BITS-1:0]  left_raw,
    input  logic [tpc_pkg::RAW_BITS-1:0]  right_raw,
    input  logic [tpc_pkg::RAW_BITS-1:0]  middle_raw,
    input  logic [tpc_pkg::TIME_BITS-1:0] now_us,
    // result output
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [1:0]                    left_event,
    output logic [1:0]                    right_event,
    output logic [1:0]                    middle_event,
    output logic [2:0]                    touching_mask,
    output logic                          lock_on,
    output logic                          lock_toggled,
    output logic                          middle_long_held,
    output logic                          stop_animation
);
    // configuration registers
    logic [tpc_pkg::RAW_BITS-1:0] threshold_reg;
    logic [tpc_pkg::DUR_BITS-1:0] long_us_reg;
    logic [tpc_pkg::DUR_BITS-1:0] lock_us_reg;

    // input stage
    logic                          in_vld_reg;
    logic [tpc_pkg::RAW_BITS-1:0]  left_raw_reg;
    logic [tpc_pkg::RAW_BITS-1:0]  right_raw_reg;
    logic [tpc_pkg::RAW_BITS-1:0]  middle_raw_reg;
    logic [tpc_pkg::TIME_BITS-1:0] now_reg;

    // lock state
    logic lock_state_reg;
    logic lock_state_next;
    logic lock_fired_reg;
    logic lock_fired_next;
    logic chord;
    logic fire;

    // result stage
    logic       out_vld_reg;
    logic [1:0] left_ev_reg;
    logic [1:0] right_ev_reg;
    logic [1:0] middle_ev_reg;
    logic [2:0] mask_reg;
    logic       lock_on_reg;
    logic       toggled_reg;
    logic       mid_long_reg;
    logic       stop_reg;

    logic advance;
    logic in_beat;

    tpc_pkg::pad_stat_t left_stat;
    tpc_pkg::pad_stat_t right_stat;
    tpc_pkg::pad_stat_t middle_stat;

    // move the scan forward when the result register is empty or being drained
    assign advance  = in_vld_reg && (!out_vld_reg || out_ready);
    assign in_ready = !in_vld_reg || advance;
    assign in_beat  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
            long_us_reg   <= tpc_pkg::LONG_US_RESET;
            lock_us_reg   <= tpc_pkg::LOCK_US_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                tpc_pkg::REG_THRESHOLD: threshold_reg <= cfg_data[tpc_pkg::RAW_BITS-1:0];
                tpc_pkg::REG_LONG_US:   long_us_reg   <= cfg_data[tpc_pkg::DUR_BITS-1:0];
                tpc_pkg::REG_LOCK_US:   lock_us_reg   <= cfg_data[tpc_pkg::DUR_BITS-1:0];
                default:                ; // unused index, write dropped
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_vld_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            left_raw_reg   <= left_raw;
            right_raw_reg  <= right_raw;
            middle_raw_reg <= middle_raw;
            now_reg        <= now_us;
        end
    end

    // per pad logic, pad state commits when the scan advances
    tpc_pad u_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .raw       (left_raw_reg),
        .now       (now_reg),
        .threshold (threshold_reg),
        .long_us   (long_us_reg),
        .lock_us   (lock_us_reg),
        .stat      (left_stat)
    );

    tpc_pad u_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .raw       (right_raw_reg),
        .now       (now_reg),
        .threshold (threshold_reg),
        .long_us   (long_us_reg),
        .lock_us   (lock_us_reg),
        .stat      (right_stat)
    );

    tpc_pad u_middle (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .raw       (middle_raw_reg),
        .now       (now_reg),
        .threshold (threshold_reg),
        .long_us   (long_us_reg),
        .lock_us   (lock_us_reg),
        .stat      (middle_stat)
    );

    // lock toggles once per left+right hold, timed from the left press
    always_comb
    begin
        chord           = left_stat.touching && right_stat.touching && !middle_stat.touching;
        fire            = chord && !lock_fired_reg && left_stat.held_lock;
        lock_fired_next = chord && (lock_fired_reg || fire);
        lock_state_next = lock_state_reg ^ fire;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_state_reg <= 1'b0;
            lock_fired_reg <= 1'b0;
        end
        else if (advance)
        begin
            lock_state_reg <= lock_state_next;
            lock_fired_reg <= lock_fired_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            left_ev_reg   <= left_stat.event_code;
            right_ev_reg  <= right_stat.event_code;
            middle_ev_reg <= middle_stat.event_code;
            mask_reg      <= {middle_stat.touching, right_stat.touching, left_stat.touching};
            lock_on_reg   <= lock_state_next;
            toggled_reg   <= fire;
            mid_long_reg  <= middle_stat.touching && !left_stat.touching
                             && !right_stat.touching && middle_stat.held_long;
            stop_reg      <= left_stat.above || right_stat.above || middle_stat.above;
        end
    end

    assign out_valid        = out_vld_reg;
    assign left_event       = left_ev_reg;
    assign right_event      = right_ev_reg;
    assign middle_event     = middle_ev_reg;
    assign touching_mask    = mask_reg;
    assign lock_on          = lock_on_reg;
    assign lock_toggled     = toggled_reg;
    assign middle_long_held = mid_long_reg;
    assign stop_animation   = stop_reg;

    `ASSERT_IMPLIES(a_toggle_chord, clk, rst_n, out_valid && lock_toggled, touching_mask == 3'b011)
    `ASSERT_IMPLIES(a_mid_alone, clk, rst_n, out_valid && middle_long_held, touching_mask == 3'b100)
    `ASSERT_IMPLIES(a_release_clear, clk, rst_n, out_valid && (left_event != tpc_pkg::EV_NONE), !touching_mask[0])
    `ASSERT_NEVER(a_fired_off_chord, clk, rst_n, lock_fired_reg && out_valid && touching_mask != 3'b011)
endmodule

[tb/tb_touch_pad_press_classifier.sv]
// self-checking testbench for the touch pad press classifier
`timescale 1ns / 1ps
module tb_touch_pad_press_classifier;
    typedef logic [tpc_pkg::RAW_BITS-1:0]  raw_t;
    typedef logic [tpc_pkg::TIME_BITS-1:0] stamp_t;
    typedef logic [tpc_pkg::CFG_BITS-1:0]  cfg_word_t;
    typedef logic [tpc_pkg::ADDR_BITS-1:0] reg_idx_t;

    // spare register index, writes to it must be ignored
    localparam reg_idx_t REG_SPARE = 2'd3;
    localparam raw_t     RAW_MAX   = '1;
    localparam stamp_t   TIME_MAX  = '1;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_PRINTS  = 40;

    // one scan as offered on the input channel
    typedef struct packed {
        raw_t   left_raw;
        raw_t   right_raw;
        raw_t   middle_raw;
        stamp_t now_us;
    } scan_t;

    // what one scan should produce on the output channel
    typedef struct packed {
        tpc_pkg::ev_t left_ev;
        tpc_pkg::ev_t right_ev;
        tpc_pkg::ev_t middle_ev;
        logic [2:0]   touching;
        logic         lock_on;
        logic         lock_toggled;
        logic         middle_long;
        logic         stop_anim;
    } press_report_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic      cfg_wr_en = 1'b0;
    reg_idx_t  cfg_addr = '0;
    cfg_word_t cfg_data = '0;

    logic   in_valid = 1'b0;
    logic   in_ready;
    raw_t   left_raw = '0;
    raw_t   right_raw = '0;
    raw_t   middle_raw = '0;
    stamp_t now_us = '0;

    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [1:0]           left_event;
    logic [1:0]           right_event;
    logic [1:0]           middle_event;
    logic [2:0]           touching_mask;
    logic                 lock_on;
    logic                 lock_toggled;
    logic                 middle_long_held;
    logic                 stop_animation;

    touch_pad_press_classifier DUT (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_addr         (cfg_addr),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .left_raw         (left_raw),
        .right_raw        (right_raw),
        .middle_raw       (middle_raw),
        .now_us           (now_us),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .left_event       (left_event),
        .right_event      (right_event),
        .middle_event     (middle_event),
        .touching_mask    (touching_mask),
        .lock_on          (lock_on),
        .lock_toggled     (lock_toggled),
        .middle_long_held (middle_long_held),
        .stop_animation   (stop_animation)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // shadow of the configuration registers, updated as they are written
    raw_t                          thr_shadow = '0;
    logic [tpc_pkg::DUR_BITS-1:0]  long_shadow = tpc_pkg::LONG_US_RESET;
    logic [tpc_pkg::DUR_BITS-1:0]  lock_shadow = tpc_pkg::LOCK_US_RESET;

    // shadow of the block state: bit0 left, bit1 right, bit2 middle
    logic [2:0] pad_down = '0;
    stamp_t     down_since [3];
    logic       lock_state = 1'b0;
    logic       lock_spent = 1'b0;

    scan_t         scan_backlog [$];
    press_report_t pending_results [$];

    int mismatches = 0;
    int scans_taken = 0;
    int results_seen = 0;
    int cycle_count = 0;

    // idling knobs, percent chance of a send gap after a beat or a receive stall
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int send_gap = 0;
    int stall_left = 0;
    logic hold_off = 1'b0;

    // timestamp cursor used while building scans
    stamp_t clock_us = '0;

    initial
    begin
        for (int i = 0; i < 3; i++)
            down_since[i] = '0;
    end

    // expected result of one scan, advancing the shadow state
    function automatic press_report_t classify_scan(scan_t s);
        press_report_t r;
        raw_t          raw [3];
        tpc_pkg::ev_t  ev [3];
        stamp_t        held;
        r = '0;
        raw[0] = s.left_raw;
        raw[1] = s.right_raw;
        raw[2] = s.middle_raw;
        for (int i = 0; i < 3; i++)
        begin
            ev[i] = tpc_pkg::EV_NONE;
            if (raw[i] > thr_shadow)
            begin
                r.stop_anim = 1'b1;
                if (!pad_down[i])
                begin
                    pad_down[i] = 1'b1;
                    down_since[i] = s.now_us;
                end
            end
            else if (pad_down[i])
            begin
                // duration is taken modulo the timestamp width
                pad_down[i] = 1'b0;
                held = s.now_us - down_since[i];
                ev[i] = (held >= stamp_t'(long_shadow)) ? tpc_pkg::EV_LONG : tpc_pkg::EV_SHORT;
            end
        end
        // lock chord is exactly left and right, timed from the left press
        if (pad_down == 3'b011)
        begin
            held = s.now_us - down_since[0];
            if (!lock_spent && held >= stamp_t'(lock_shadow))
            begin
                lock_state = !lock_state;
                lock_spent = 1'b1;
                r.lock_toggled = 1'b1;
            end
        end
        else
            lock_spent = 1'b0;
        held = s.now_us - down_since[2];
        r.middle_long = (pad_down == 3'b100) && (held >= stamp_t'(long_shadow));
        r.left_ev = ev[0];
        r.right_ev = ev[1];
        r.middle_ev = ev[2];
        r.touching = pad_down;
        r.lock_on = lock_state;
        return r;
    endfunction

    task automatic report(string msg);
        mismatches++;
        if (mismatches <= MAX_PRINTS)
            $display("ERROR at %0t ns: %s", $time, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report($sformatf("result %0d field %s got %0d want %0d",
                             results_seen, name, got, want));
    endtask

    // run-away guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // sender: predicts each accepted beat, then offers the next scan or idles
    always @(posedge clk)
    begin
        scan_t cur;
        scan_t nxt;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                cur.left_raw = left_raw;
                cur.right_raw = right_raw;
                cur.middle_raw = middle_raw;
                cur.now_us = now_us;
                pending_results.push_back(classify_scan(cur));
                scans_taken++;
                if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct)
                    send_gap = $urandom_range(1, 5);
            end
            // the slot is free when nothing is offered or the offer just went through
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (scan_backlog.size() > 0)
                begin
                    nxt = scan_backlog.pop_front();
                    in_valid <= 1'b1;
                    left_raw <= nxt.left_raw;
                    right_raw <= nxt.right_raw;
                    middle_raw <= nxt.middle_raw;
                    now_us <= nxt.now_us;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: checks every result beat against the oldest prediction
    always @(posedge clk)
    begin
        press_report_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (pending_results.size() == 0)
                    report($sformatf("result %0d arrived with no scan waiting", results_seen));
                else
                begin
                    want = pending_results.pop_front();
                    check_field("left_event", 8'(left_event), 8'(want.left_ev));
                    check_field("right_event", 8'(right_event), 8'(want.right_ev));
                    check_field("middle_event", 8'(middle_event), 8'(want.middle_ev));
                    check_field("touching_mask", 8'(touching_mask), 8'(want.touching));
                    check_field("lock_on", 8'(lock_on), 8'(want.lock_on));
                    check_field("lock_toggled", 8'(lock_toggled), 8'(want.lock_toggled));
                    check_field("middle_long_held", 8'(middle_long_held),
                                8'(want.middle_long));
                    check_field("stop_animation", 8'(stop_animation), 8'(want.stop_anim));
                end
            end
            if (stall_left > 0)
                stall_left--;
            else if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct)
                stall_left = $urandom_range(1, 5);
            out_ready <= !hold_off && (stall_left == 0);
        end
    end

    // back-pressure: long output hold-offs so the block fills and stalls its input
    initial
    begin
        wait (scans_taken >= 300);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (60) @(posedge clk);
        hold_off <= 1'b0;
        wait (scans_taken >= 1000);
        @(posedge clk);
        hold_off <= 1'b1;
        repeat (80) @(posedge clk);
        hold_off <= 1'b0;
    end

    // register write, only issued while the block is idle
    task automatic set_reg(reg_idx_t idx, cfg_word_t val);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        case (idx)
            tpc_pkg::REG_THRESHOLD: thr_shadow = val[tpc_pkg::RAW_BITS-1:0];
            tpc_pkg::REG_LONG_US:   long_shadow = val[tpc_pkg::DUR_BITS-1:0];
            tpc_pkg::REG_LOCK_US:   lock_shadow = val[tpc_pkg::DUR_BITS-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic queue_raw(raw_t l, raw_t r, raw_t m, stamp_t t);
        scan_t s;
        s.left_raw = l;
        s.right_raw = r;
        s.middle_raw = m;
        s.now_us = t;
        clock_us = t;
        scan_backlog.push_back(s);
    endtask

    // reading on the touched or released side of the threshold, often right at it
    function automatic raw_t pad_reading(bit pressed);
        if (pressed && thr_shadow != RAW_MAX)
        begin
            if ($urandom_range(0, 3) == 0)
                return thr_shadow + raw_t'(1);
            return raw_t'($urandom_range(32'(thr_shadow) + 1, 32'(RAW_MAX)));
        end
        if ($urandom_range(0, 3) == 0)
            return thr_shadow;
        return raw_t'($urandom_range(0, 32'(thr_shadow)));
    endfunction

    // press sessions: a pad pattern held for a few scans, then released,
    // mixed with a little noise (random readings and timestamp jumps)
    task automatic queue_touch_session(int count, int unsigned dt_max);
        logic [2:0] pads;
        int         hold;
        int         sel;
        int         made;
        made = 0;
        while (made < count)
        begin
            sel = $urandom_range(0, 9);
            if (sel == 9)
            begin
                // noise beat
                if ($urandom_range(0, 1) == 0)
                    clock_us = clock_us + stamp_t'({$urandom, $urandom});
                queue_raw(raw_t'($urandom), raw_t'($urandom), raw_t'($urandom),
                          clock_us + stamp_t'($urandom_range(0, dt_max)));
                made++;
            end
            else
            begin
                case (sel)
                    0, 1, 2: pads = 3'b011;
                    3:       pads = 3'b111;
                    4, 5:    pads = 3'b100;
                    6:       pads = 3'b001 << $urandom_range(0, 1);
                    default: pads = 3'($urandom);
                endcase
                hold = $urandom_range(1, 10);
                for (int j = 0; j < hold && made < count; j++)
                begin
                    // now and then one pad changes mid-hold, breaking or forming a chord
                    if ($urandom_range(0, 7) == 0)
                        pads = pads ^ (3'b001 << $urandom_range(0, 2));
                    queue_raw(pad_reading(pads[0]), pad_reading(pads[1]),
                              pad_reading(pads[2]),
                              clock_us + stamp_t'($urandom_range(0, dt_max)));
                    made++;
                end
                queue_raw(pad_reading(1'b0), pad_reading(1'b0), pad_reading(1'b0),
                          clock_us + stamp_t'($urandom_range(0, dt_max)));
                made++;
            end
        end
    endtask

    // wait for every queued scan to go in and every result to come out
    task automatic drain_pipeline();
        while (scan_backlog.size() != 0 || in_valid || pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic play_setting(cfg_word_t thr, cfg_word_t long_us, cfg_word_t lock_us,
                                int count, int unsigned dt_max);
        set_reg(tpc_pkg::REG_THRESHOLD, thr);
        set_reg(tpc_pkg::REG_LONG_US, long_us);
        set_reg(tpc_pkg::REG_LOCK_US, lock_us);
        queue_touch_session(count, dt_max);
        drain_pipeline();
    endtask

    initial
    begin
        int unsigned lp;
        int unsigned lh;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with reset settings: threshold 0, long 1 s, lock 2.5 s
        send_idle_pct = 25;
        recv_stall_pct = 25;
        queue_raw(0, 0, 0, 100);
        queue_raw(RAW_MAX, RAW_MAX, RAW_MAX, 200);
        // release exactly at the long press time counts as long
        queue_raw(0, 0, 0, 200 + 1000000);
        queue_raw(1, 0, 0, 2000000);
        queue_raw(0, 0, 0, 2999999);
        // left and right chord, one microsecond short of the lock time then at it
        queue_raw(5, 7, 0, 4000000);
        queue_raw(5, 7, 0, 6499999);
        queue_raw(5, 7, 0, 6500000);
        queue_raw(5, 7, 0, 7000000);
        // right lets go, which re-arms; its return toggles again off the left start
        queue_raw(5, 0, 0, 7100000);
        queue_raw(5, 9, 0, 7200000);
        // middle joins and breaks the chord, then stays alone until long held
        queue_raw(5, 9, 3, 7300000);
        queue_raw(0, 0, 3, 7400000);
        queue_raw(0, 0, 3, 8300000);
        queue_raw(0, 0, 0, 8400000);
        // press across the timestamp wrap
        queue_raw(RAW_MAX, 0, 0, TIME_MAX - 9);
        queue_raw(0, 0, 0, 5);
        drain_pipeline();

        // spare index is ignored; zero hold times toggle on the first chord scan
        set_reg(REG_SPARE, '1);
        set_reg(tpc_pkg::REG_THRESHOLD, 100);
        set_reg(tpc_pkg::REG_LONG_US, 0);
        set_reg(tpc_pkg::REG_LOCK_US, 0);
        queue_raw(101, 101, 0, 10);
        queue_raw(100, 100, 0, 10);
        drain_pipeline();
        // upper data bits fall away, leaving the top threshold: nothing can touch
        set_reg(tpc_pkg::REG_THRESHOLD, '1);
        queue_raw(RAW_MAX, RAW_MAX, RAW_MAX, 20);
        drain_pipeline();

        // random part, short times so presses and locks land on both sides
        play_setting($urandom_range(0, RAW_MAX), 100, 250, 300, 40);
        // no idling through this stretch
        send_idle_pct = 0;
        recv_stall_pct = 0;
        play_setting(0, 0, 0, 150, 3);
        send_idle_pct = 30;
        recv_stall_pct = 30;
        play_setting('1, '1, '1, 60, 1000);
        // longest hold times with huge steps, starting just below the wrap
        clock_us = TIME_MAX - 48'h0000_8000_0000;
        play_setting($urandom_range(0, RAW_MAX), '1, '1, 200, 32'h4000_0000);
        for (int p = 0; p < 3; p++)
        begin
            lp = $urandom_range(1, 2000);
            lh = $urandom_range(1, 4000);
            play_setting($urandom_range(0, RAW_MAX), lp, lh, 250, (lp + lh) / 8 + 1);
        end

        // last part runs without idling on either side
        send_idle_pct = 0;
        recv_stall_pct = 0;
        play_setting($urandom_range(0, 1000), 500, 1200, 270, 150);

        if (pending_results.size() != 0)
            report($sformatf("%0d results never arrived", pending_results.size()));
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
